// ===== hdl/slsg_pkg.sv =====
// Package for the slew-limited stereo gain block.
// Holds the configuration register map and fixed sizing constants.
// No dependencies; slsg_front and the core import it.
package slsg_pkg;

  // Width of the configuration register index.
  localparam int unsigned CFG_ADDR_BITS = 3;

  // Depth of the queue between the front and the back.
  localparam int unsigned QUEUE_DEPTH = 2;

  // Frames in the default ramp: 5 ms at 48 kHz.
  localparam int unsigned RAMP_FRAMES = 240;

  // Configuration register indexes.
  typedef enum logic [CFG_ADDR_BITS-1:0] {
    REG_TARGET_GAIN   = 3'd0,
    REG_STEP_SIZE     = 3'd1,
    REG_INPUT_STEREO  = 3'd2,
    REG_OUTPUT_STEREO = 3'd3
  } cfg_reg_e;

endpackage

// ===== hdl/slsg_fifo.sv =====
// Short register queue that decouples the front from the back.
// Generic in width and depth; uses no package.
module slsg_fifo #(
  parameter int unsigned WIDTH = 65,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] rdata_o
);

  localparam int unsigned PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_BITS = $clog2(DEPTH + 1);
  localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(DEPTH - 1);
  localparam logic [CNT_BITS-1:0] FULL_CNT = CNT_BITS'(DEPTH);

  logic [WIDTH-1:0]    entry_q [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_BITS-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_BITS-1:0] count_q, count_d;

  // Status toward both sides.
  assign full_o  = (count_q == FULL_CNT);
  assign valid_o = (count_q != '0);
  assign rdata_o = entry_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= wdata_i;
    end
  end

  // The fill count never passes the depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= FULL_CNT)
    else $error("queue fill count above depth");

  // The back never pops an empty queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> count_q != '0)
    else $error("pop from empty queue");

  // A push without a pop grows the fill count by one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> count_q == $past(count_q) + 1'b1)
    else $error("queue fill count lost a push");

endmodule

// ===== hdl/slsg_front.sv =====
// Front part: configuration registers, gain ramp and frame classification.
// Depends on slsg_pkg; pushes one prepared request per frame into the queue.
module slsg_front #(
  parameter int unsigned SAMPLE_BITS    = 24,
  parameter int unsigned GAIN_FRAC_BITS = 16
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // Configuration write channel.
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [slsg_pkg::CFG_ADDR_BITS-1:0]     cfg_addr_i,
  input  logic [GAIN_FRAC_BITS:0]                cfg_data_i,
  // Frame input channel.
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0]          left_sample_i,
  input  logic signed [SAMPLE_BITS-1:0]          right_sample_i,
  // Queue write side.
  input  logic                                   q_full_i,
  output logic                                   q_push_o,
  output logic [2*SAMPLE_BITS+GAIN_FRAC_BITS:0]  q_data_o
);

  import slsg_pkg::*;

  localparam int unsigned GAIN_BITS = GAIN_FRAC_BITS + 1;
  localparam logic [GAIN_BITS-1:0] UNITY = GAIN_BITS'(1) << GAIN_FRAC_BITS;
  localparam logic [GAIN_BITS-1:0] STEP_RESET = GAIN_BITS'((1 << GAIN_FRAC_BITS) / RAMP_FRAMES);

  logic [GAIN_BITS-1:0] target_q, target_d;
  logic [GAIN_BITS-1:0] step_q, step_d;
  logic                 in_stereo_q, in_stereo_d;
  logic                 out_stereo_q, out_stereo_d;
  logic [GAIN_BITS-1:0] gain_q, gain_d;

  logic                 cfg_write;
  logic [GAIN_BITS-1:0] cfg_gain_sat;
  logic                 push;
  logic                 ramp_up;
  logic [GAIN_BITS-1:0] gain_diff;
  logic [GAIN_BITS-1:0] gain_delta;
  logic signed [SAMPLE_BITS-1:0] right_sel;
  logic signed [SAMPLE_BITS:0]   pair_sum;
  logic signed [SAMPLE_BITS-1:0] op_a;
  logic signed [SAMPLE_BITS-1:0] op_b;

  // Configuration writes are always taken; gain values clamp to unity.
  assign cfg_ready_o  = 1'b1;
  assign cfg_write    = cfg_valid_i;
  assign cfg_gain_sat = (cfg_data_i > UNITY) ? UNITY : cfg_data_i;

  always_comb begin
    target_d     = target_q;
    step_d       = step_q;
    in_stereo_d  = in_stereo_q;
    out_stereo_d = out_stereo_q;
    if (cfg_write) begin
      case (cfg_addr_i)
        REG_TARGET_GAIN:   target_d     = cfg_gain_sat;
        REG_STEP_SIZE:     step_d       = cfg_gain_sat;
        REG_INPUT_STEREO:  in_stereo_d  = cfg_data_i[0];
        REG_OUTPUT_STEREO: out_stereo_d = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // A frame is taken whenever the queue has room.
  assign in_stall_o = q_full_i;
  assign push       = in_valid_i && !q_full_i;
  assign q_push_o   = push;

  // Move the gain toward the target by at most one step per frame.
  assign ramp_up    = (target_q > gain_q);
  assign gain_diff  = ramp_up ? (target_q - gain_q) : (gain_q - target_q);
  assign gain_delta = (gain_diff < step_q) ? gain_diff : step_q;

  always_comb begin
    gain_d = gain_q;
    if (push) begin
      gain_d = ramp_up ? (gain_q + gain_delta) : (gain_q - gain_delta);
    end
  end

  // Mono input copies left into right; mono output averages the pair.
  assign right_sel = in_stereo_q ? right_sample_i : left_sample_i;
  assign pair_sum  = {left_sample_i[SAMPLE_BITS-1], left_sample_i}
                   + {right_sel[SAMPLE_BITS-1], right_sel};
  assign op_a      = out_stereo_q ? left_sample_i : pair_sum[SAMPLE_BITS:1];
  assign op_b      = out_stereo_q ? right_sel : '0;
  assign q_data_o  = {op_a, op_b, gain_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q     <= UNITY;
      step_q       <= STEP_RESET;
      in_stereo_q  <= 1'b1;
      out_stereo_q <= 1'b1;
      gain_q       <= UNITY;
    end else begin
      target_q     <= target_d;
      step_q       <= step_d;
      in_stereo_q  <= in_stereo_d;
      out_stereo_q <= out_stereo_d;
      gain_q       <= gain_d;
    end
  end

  // The running gain never exceeds unity.
  assert property (@(posedge clk_i) disable iff (!rst_ni) gain_q <= UNITY)
    else $error("current gain above unity");

  // Stored target and step stay clamped.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (target_q <= UNITY) && (step_q <= UNITY))
    else $error("target or step above unity");

  // The gain only moves when a frame is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !push |=> $stable(gain_q))
    else $error("gain changed without a frame");

endmodule

// ===== hdl/slsg_back.sv =====
// Back part: two-lane gain multiply, rounding, saturation and output register.
// Pops prepared requests from the queue; uses no package.
module slsg_back #(
  parameter int unsigned SAMPLE_BITS    = 24,
  parameter int unsigned GAIN_FRAC_BITS = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // Queue read side.
  input  logic                                  q_valid_i,
  input  logic [2*SAMPLE_BITS+GAIN_FRAC_BITS:0] q_data_i,
  output logic                                  q_pop_o,
  // Result channel.
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [SAMPLE_BITS-1:0]         out_left_o,
  output logic signed [SAMPLE_BITS-1:0]         out_right_o
);

  localparam int unsigned GAIN_BITS = GAIN_FRAC_BITS + 1;
  localparam int unsigned PROD_BITS = SAMPLE_BITS + GAIN_BITS + 1;
  localparam logic signed [PROD_BITS-1:0] ROUND_HALF = PROD_BITS'(1) << (GAIN_FRAC_BITS - 1);

  logic signed [SAMPLE_BITS-1:0] op_a;
  logic signed [SAMPLE_BITS-1:0] op_b;
  logic signed [GAIN_BITS:0]     gain_s;
  logic signed [PROD_BITS-1:0]   prod_a, prod_b;

  logic                          s1_valid_q;
  logic signed [PROD_BITS-1:0]   prod_a_q, prod_b_q;
  logic                          s1_ready;
  logic                          s2_ready;
  logic                          out_valid_q;
  logic signed [SAMPLE_BITS-1:0] out_left_q, out_left_d;
  logic signed [SAMPLE_BITS-1:0] out_right_q, out_right_d;

  // Round to nearest with ties upward, then clamp to the sample range.
  function automatic logic signed [SAMPLE_BITS-1:0] round_sat(
    input logic signed [PROD_BITS-1:0] prod
  );
    logic signed [PROD_BITS-1:0]   biased;
    logic signed [PROD_BITS-1:0]   shifted;
    logic signed [SAMPLE_BITS+1:0] narrow;
    logic signed [SAMPLE_BITS-1:0] res;
    biased  = prod + ROUND_HALF;
    shifted = biased >>> GAIN_FRAC_BITS;
    narrow  = shifted[SAMPLE_BITS+1:0];
    if ((narrow[SAMPLE_BITS+1] == narrow[SAMPLE_BITS])
        && (narrow[SAMPLE_BITS] == narrow[SAMPLE_BITS-1])) begin
      res = narrow[SAMPLE_BITS-1:0];
    end else if (narrow[SAMPLE_BITS+1]) begin
      res = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      res = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end
    return res;
  endfunction

  // Pipeline flow control: each stage moves when the next one has room.
  assign s2_ready = !out_valid_q || !out_stall_i;
  assign s1_ready = !s1_valid_q || s2_ready;
  assign q_pop_o  = q_valid_i && s1_ready;

  // Unpack the request and multiply both lanes by the gain.
  assign op_a   = q_data_i[2*SAMPLE_BITS+GAIN_FRAC_BITS -: SAMPLE_BITS];
  assign op_b   = q_data_i[SAMPLE_BITS+GAIN_FRAC_BITS -: SAMPLE_BITS];
  assign gain_s = {1'b0, q_data_i[GAIN_BITS-1:0]};
  assign prod_a = op_a * gain_s;
  assign prod_b = op_b * gain_s;

  // Second stage results.
  assign out_left_d  = round_sat(prod_a_q);
  assign out_right_d = round_sat(prod_b_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_q <= q_valid_i;
      end
      if (s2_ready) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  // Payload registers hold while their stage is stalled.
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      prod_a_q <= prod_a;
      prod_b_q <= prod_b;
    end
    if (s2_ready && s1_valid_q) begin
      out_left_q  <= out_left_d;
      out_right_q <= out_right_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_left_o  = out_left_q;
  assign out_right_o = out_right_q;

endmodule

// ===== hdl/slew_limited_stereo_gain_core.sv =====
// Slew-limited stereo gain: ramps a gain toward a target and scales audio frames.
// An accepted frame passes the queue, the product registers and the output register.
// Throughput: one frame per clock while the output is not stalled; the back holds product and output registers.
// A two-entry queue between classifier and multiplier absorbs output stalls.
// Reset (async, active low) sets unity target and gain, step 1/240 of unity, stereo in/out.
// Depends on slsg_pkg, slsg_front, slsg_fifo and slsg_back.
module slew_limited_stereo_gain_core #(
  parameter int unsigned SAMPLE_BITS    = 24,
  parameter int unsigned GAIN_FRAC_BITS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Configuration write channel.
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [slsg_pkg::CFG_ADDR_BITS-1:0] cfg_addr_i,
  input  logic [GAIN_FRAC_BITS:0]            cfg_data_i,
  // Frame input channel.
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0]      left_sample_i,
  input  logic signed [SAMPLE_BITS-1:0]      right_sample_i,
  // Result channel.
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [SAMPLE_BITS-1:0]      out_left_o,
  output logic signed [SAMPLE_BITS-1:0]      out_right_o
);

  import slsg_pkg::*;

  localparam int unsigned REQ_BITS = 2 * SAMPLE_BITS + GAIN_FRAC_BITS + 1;

  logic                q_push;
  logic                q_full;
  logic [REQ_BITS-1:0] q_wdata;
  logic                q_valid;
  logic                q_pop;
  logic [REQ_BITS-1:0] q_rdata;

  // Front: configuration, gain ramp and request preparation.
  slsg_front #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_addr_i     (cfg_addr_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .left_sample_i  (left_sample_i),
    .right_sample_i (right_sample_i),
    .q_full_i       (q_full),
    .q_push_o       (q_push),
    .q_data_o       (q_wdata)
  );

  // Request queue between the two halves.
  slsg_fifo #(
    .WIDTH (REQ_BITS),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .rdata_o (q_rdata)
  );

  // Back: multiply, round, saturate and present results.
  slsg_back #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (q_rdata),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_left_o  (out_left_o),
    .out_right_o (out_right_o)
  );

endmodule
